// ----- sv/cde_pkg.sv -----
// Shared types, constants and calendar helpers for the civil date to epoch
// seconds converter. Used by cde_mac, cde_ctrl and civil_date_to_epoch_seconds.
// No dependencies.
package cde_pkg;

  localparam int YEAR_W   = 8;
  localparam int MONTH_W  = 4;
  localparam int MDAY_W   = 5;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int SEC_W    = 6;
  localparam int ACC_W    = 33;
  localparam int MUL_W    = 6;
  localparam int DAYS_W   = 9;

  localparam logic [YEAR_W-1:0]  EPOCH_YOFF    = 8'd70;
  localparam logic [YEAR_W-1:0]  YOFF_1900     = 8'd0;
  localparam logic [YEAR_W-1:0]  YOFF_2100     = 8'd200;
  localparam logic [MONTH_W-1:0] MONTHS_PER_YR = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd1;

  localparam logic [DAYS_W-1:0] DAYS_COMMON = 9'd365;
  localparam logic [DAYS_W-1:0] DAYS_LEAP   = 9'd366;

  localparam logic [MUL_W-1:0] MUL_ONE      = 6'd1;
  localparam logic [MUL_W-1:0] HOURS_PER_DY = 6'd24;
  localparam logic [MUL_W-1:0] MINS_PER_HR  = 6'd60;
  localparam logic [MUL_W-1:0] SECS_PER_MIN = 6'd60;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEAR,
    ST_MONTH,
    ST_DAY,
    ST_HOUR,
    ST_MIN,
    ST_SEC,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    OP_DAYS,
    OP_MDAY,
    OP_HOUR,
    OP_MIN,
    OP_SEC
  } op_e;

  typedef struct packed {
    logic              acc_clr;
    logic              acc_en;
    op_e               op;
    logic [DAYS_W-1:0] days;
    logic              load_out;
  } ctrl_t;

  // Years held here run from 1900 to 2155, so the only century years that
  // can appear are 1900, 2000 and 2100; of those only 2000 is a leap year.
  function automatic logic is_leap(input logic [YEAR_W-1:0] yoff);
    return (yoff[1:0] == 2'b00) && (yoff != YOFF_1900) && (yoff != YOFF_2100);
  endfunction

  function automatic logic [DAYS_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [DAYS_W-1:0] d;
    d = 9'd31;
    unique case (m)
      4'd1:    d = leap ? 9'd29 : 9'd28;
      4'd3:    d = 9'd30;
      4'd5:    d = 9'd30;
      4'd8:    d = 9'd30;
      4'd10:   d = 9'd30;
      default: d = 9'd31;
    endcase
    return d;
  endfunction

endpackage

// ----- sv/cde_mac.sv -----
// Shared multiply-accumulate unit: result = acc * mul + addend, modulo 2^33.
// Depends on cde_pkg.
module cde_mac (
  input  logic [cde_pkg::ACC_W-1:0] acc_i,
  input  logic [cde_pkg::MUL_W-1:0] mul_i,
  input  logic [cde_pkg::ACC_W-1:0] addend_i,
  output logic [cde_pkg::ACC_W-1:0] res_o
);
  import cde_pkg::*;

  logic [ACC_W+MUL_W-1:0] prod;

  assign prod  = {{MUL_W{1'b0}}, acc_i} * {{ACC_W{1'b0}}, mul_i};
  assign res_o = prod[ACC_W-1:0] + addend_i;

endmodule

// ----- sv/cde_ctrl.sv -----
// Sequencer for the converter: walks the years, then the months, then the
// day and time terms, steering the shared unit. Depends on cde_pkg.
module cde_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_accept_i,
  input  logic [cde_pkg::YEAR_W-1:0]  year_i,
  input  logic [cde_pkg::MONTH_W-1:0] month_i,
  input  logic                        out_free_i,
  output logic                        in_ready_o,
  output cde_pkg::ctrl_t              ctrl_o
);
  import cde_pkg::*;

  state_e               state_q, state_d;
  logic [YEAR_W-1:0]    year_cnt_q, year_cnt_d;
  logic [YEAR_W-1:0]    yoff_q, yoff_d;
  logic [MONTH_W-1:0]   mon_cnt_q, mon_cnt_d;
  logic [MONTH_W-1:0]   mon_q, mon_d;
  logic                 year_end;
  logic                 mon_end;

  assign year_end = (year_cnt_q == yoff_q);
  assign mon_end  = (mon_cnt_q == mon_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept_i) begin
          state_d = (year_i < EPOCH_YOFF) ? ST_DONE : ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (year_end) begin
          state_d = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (mon_end) begin
          state_d = ST_DAY;
        end
      end
      ST_DAY:  state_d = ST_HOUR;
      ST_HOUR: state_d = ST_MIN;
      ST_MIN:  state_d = ST_SEC;
      ST_SEC:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs to the datapath.
  always_comb begin
    in_ready_o      = 1'b0;
    ctrl_o.acc_clr  = 1'b0;
    ctrl_o.acc_en   = 1'b0;
    ctrl_o.op       = OP_DAYS;
    ctrl_o.days     = '0;
    ctrl_o.load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        ctrl_o.acc_clr = in_accept_i;
      end
      ST_YEAR: begin
        ctrl_o.acc_en = !year_end;
        ctrl_o.days   = is_leap(year_cnt_q) ? DAYS_LEAP : DAYS_COMMON;
      end
      ST_MONTH: begin
        ctrl_o.acc_en = !mon_end;
        ctrl_o.days   = month_days(mon_cnt_q, is_leap(yoff_q));
      end
      ST_DAY: begin
        ctrl_o.acc_en = 1'b1;
        ctrl_o.op     = OP_MDAY;
      end
      ST_HOUR: begin
        ctrl_o.acc_en = 1'b1;
        ctrl_o.op     = OP_HOUR;
      end
      ST_MIN: begin
        ctrl_o.acc_en = 1'b1;
        ctrl_o.op     = OP_MIN;
      end
      ST_SEC: begin
        ctrl_o.acc_en = 1'b1;
        ctrl_o.op     = OP_SEC;
      end
      ST_DONE: begin
        ctrl_o.load_out = out_free_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Loop counters and the loop bounds of the word in flight.
  always_comb begin
    year_cnt_d = year_cnt_q;
    yoff_d     = yoff_q;
    mon_cnt_d  = mon_cnt_q;
    mon_d      = mon_q;
    if (in_accept_i) begin
      year_cnt_d = EPOCH_YOFF;
      yoff_d     = year_i;
      mon_cnt_d  = '0;
      // Months beyond December count as a whole year of months.
      mon_d      = (month_i > MONTHS_PER_YR) ? MONTHS_PER_YR : month_i;
    end else if (state_q == ST_YEAR && !year_end) begin
      year_cnt_d = year_cnt_q + YEAR_W'(1);
    end else if (state_q == ST_MONTH && !mon_end) begin
      mon_cnt_d = mon_cnt_q + MONTH_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      year_cnt_q <= '0;
      yoff_q     <= '0;
      mon_cnt_q  <= '0;
      mon_q      <= '0;
    end else begin
      state_q    <= state_d;
      year_cnt_q <= year_cnt_d;
      yoff_q     <= yoff_d;
      mon_cnt_q  <= mon_cnt_d;
      mon_q      <= mon_d;
    end
  end

`ifndef ASSERT_OFF
  a_year_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_YEAR) |-> (year_cnt_q <= yoff_q && yoff_q >= EPOCH_YOFF))
    else $error("year counter ran past the target year");

  a_mon_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MONTH) |-> (mon_cnt_q <= mon_q && mon_q <= MONTHS_PER_YR))
    else $error("month counter ran past the target month");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept_i |=> (state_q != ST_IDLE))
    else $error("accepted word did not start a conversion");

  a_short_year_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept_i && year_i < EPOCH_YOFF) |=> (state_q == ST_DONE))
    else $error("year before 1970 did not finish at once");
`endif

endmodule

// ----- sv/civil_date_to_epoch_seconds.sv -----
// From acceptance the sequencer steps one year at a time from 1970 up to the target year,
// then one month at a time up to min(month, 12), then the day, hour, minute and second terms;
// a year before 1970 goes straight to the result, which is then zero. The year loop runs
// through the shared multiply-accumulate unit, one year per cycle.
// A new word is taken while the previous result still waits in the output register.
// Reset (rst_ni low, asynchronous) empties the output and returns the sequencer to idle.
module civil_date_to_epoch_seconds (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [cde_pkg::YEAR_W-1:0]  year_since_1900_i,
  input  logic [cde_pkg::MONTH_W-1:0] month_index_i,
  input  logic [cde_pkg::MDAY_W-1:0]  day_of_month_i,
  input  logic [cde_pkg::HOUR_W-1:0]  hour_of_day_i,
  input  logic [cde_pkg::MIN_W-1:0]   minute_of_hour_i,
  input  logic [cde_pkg::SEC_W-1:0]   second_of_minute_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [cde_pkg::ACC_W-1:0]   epoch_seconds_o
);
  import cde_pkg::*;

  ctrl_t               ctrl;
  logic                in_accept;
  logic                out_free;
  logic [MDAY_W-1:0]   mday_q;
  logic [HOUR_W-1:0]   hour_q;
  logic [MIN_W-1:0]    min_q;
  logic [SEC_W-1:0]    sec_q;
  logic [ACC_W-1:0]    acc_q;
  logic [ACC_W-1:0]    out_q;
  logic                out_valid_q, out_valid_d;
  logic [MUL_W-1:0]    mul;
  logic [ACC_W-1:0]    addend;
  logic [ACC_W-1:0]    mac_res;

  assign in_accept = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;

  cde_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .year_i      (year_since_1900_i),
    .month_i     (month_index_i),
    .out_free_i  (out_free),
    .in_ready_o  (in_ready_o),
    .ctrl_o      (ctrl)
  );

  // Operand selection for the shared unit. The day term is (day - 1), taken
  // modulo 2^33 so that a day of zero steps back one day.
  always_comb begin
    mul    = MUL_ONE;
    addend = ACC_W'(ctrl.days);
    unique case (ctrl.op)
      OP_DAYS: begin
        mul    = MUL_ONE;
        addend = ACC_W'(ctrl.days);
      end
      OP_MDAY: begin
        mul    = MUL_ONE;
        addend = ACC_W'(mday_q) - ACC_W'(1);
      end
      OP_HOUR: begin
        mul    = HOURS_PER_DY;
        addend = ACC_W'(hour_q);
      end
      OP_MIN: begin
        mul    = MINS_PER_HR;
        addend = ACC_W'(min_q);
      end
      OP_SEC: begin
        mul    = SECS_PER_MIN;
        addend = ACC_W'(sec_q);
      end
      default: begin
        mul    = MUL_ONE;
        addend = '0;
      end
    endcase
  end

  cde_mac u_mac (
    .acc_i    (acc_q),
    .mul_i    (mul),
    .addend_i (addend),
    .res_o    (mac_res)
  );

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mday_q <= day_of_month_i;
      hour_q <= hour_of_day_i;
      min_q  <= minute_of_hour_i;
      sec_q  <= second_of_minute_i;
    end
    if (ctrl.acc_clr) begin
      acc_q <= '0;
    end else if (ctrl.acc_en) begin
      acc_q <= mac_res;
    end
    if (ctrl.load_out) begin
      out_q <= acc_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign epoch_seconds_o = out_q;

endmodule

// ----- tb/sv/civil_date_to_epoch_seconds_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for civil_date_to_epoch_seconds: a queue-fed driver with bursts and
// gaps, a stalling monitor and an in-bench calendar predictor. Depends on cde_pkg and the DUT.
module civil_date_to_epoch_seconds_tb;

  localparam int unsigned FIRST_YEAR     = 1970;
  localparam int unsigned BASE_YEAR      = 1900;
  localparam int          RANDOM_DATES   = 1630;
  localparam int          HOLD_AT_RESULT = 600;
  localparam int          HOLD_CYCLES    = 800;
  localparam int          TAIL_CYCLES    = 250;

  typedef struct packed {
    logic [cde_pkg::YEAR_W-1:0]  yoff;
    logic [cde_pkg::MONTH_W-1:0] mon;
    logic [cde_pkg::MDAY_W-1:0]  mday;
    logic [cde_pkg::HOUR_W-1:0]  hour;
    logic [cde_pkg::MIN_W-1:0]   min;
    logic [cde_pkg::SEC_W-1:0]   sec;
    logic                        drain_first;
  } civil_date_t;

  typedef struct packed {
    civil_date_t               date;
    logic [cde_pkg::ACC_W-1:0] epoch;
  } epoch_expect_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [cde_pkg::ACC_W-1:0] epoch_seconds_o;
  civil_date_t offered_date = '0;

  civil_date_t   pending_dates_q[$];
  epoch_expect_t expected_epoch_q[$];
  epoch_expect_t oldest_expect;

  int burst_left = 0;
  int gap_left = 0;
  int words_taken = 0;
  int results_seen = 0;
  int mismatches = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic [31:0] stall_cycle = '0;

  always #2 clk_i = ~clk_i;

  civil_date_to_epoch_seconds DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .year_since_1900_i  (offered_date.yoff),
    .month_index_i      (offered_date.mon),
    .day_of_month_i     (offered_date.mday),
    .hour_of_day_i      (offered_date.hour),
    .minute_of_hour_i   (offered_date.min),
    .second_of_minute_i (offered_date.sec),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .epoch_seconds_o    (epoch_seconds_o)
  );

  function automatic bit gregorian_leap(input int unsigned cal_year);
    return (cal_year % 4 == 0) && ((cal_year % 100 != 0) || (cal_year % 400 == 0));
  endfunction

  function automatic logic [cde_pkg::ACC_W-1:0] epoch_of_date(input civil_date_t d);
    int unsigned     cal_year;
    int unsigned     whole_months;
    longint unsigned days;
    longint unsigned secs;
    bit              leap;
    days = 0;
    if (d.yoff < cde_pkg::EPOCH_YOFF) return '0;
    cal_year = BASE_YEAR + d.yoff;
    for (int unsigned y = FIRST_YEAR; y < cal_year; y++) begin
      days += gregorian_leap(y) ? 366 : 365;
    end
    leap = gregorian_leap(cal_year);
    // Months past December count the whole year and nothing more.
    whole_months = (d.mon > 12) ? 12 : d.mon;
    for (int unsigned m = 0; m < whole_months; m++) begin
      case (m)
        1:          days += leap ? 29 : 28;
        3, 5, 8, 10: days += 30;
        default:    days += 31;
      endcase
    end
    // A day of zero steps back one day; the sum wraps within the output width.
    days = days + d.mday - 1;
    secs = ((days * 24 + d.hour) * 60 + d.min) * 60 + d.sec;
    return secs[cde_pkg::ACC_W-1:0];
  endfunction

  task automatic add_date(input int y, input int mo, input int dy, input int h, input int mi,
                          input int s);
    civil_date_t d;
    d = '0;
    d.yoff = y[cde_pkg::YEAR_W-1:0];
    d.mon  = mo[cde_pkg::MONTH_W-1:0];
    d.mday = dy[cde_pkg::MDAY_W-1:0];
    d.hour = h[cde_pkg::HOUR_W-1:0];
    d.min  = mi[cde_pkg::MIN_W-1:0];
    d.sec  = s[cde_pkg::SEC_W-1:0];
    pending_dates_q.push_back(d);
  endtask

  // Driver: bursts of words separated by gaps, with a long run of back-to-back words
  // every so often. A word marked drain_first waits until every result has come back.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        expected_epoch_q.push_back('{date: offered_date, epoch: epoch_of_date(offered_date)});
        words_taken++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if ((words_taken % 512) < 128 || $urandom_range(0, 3) == 0) gap_left = 0;
          else gap_left = $urandom_range(1, 12);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_dates_q.size() != 0 &&
                   (!pending_dates_q[0].drain_first || words_taken == results_seen)) begin
        offered_date <= pending_dates_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: checks each result against the oldest expectation and stalls on a pattern chosen by
  // bits 9:8 of a free-running counter, plus one long hold-off so the converter backs up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen <= results_seen + 1;
        if (expected_epoch_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word: got %0d", epoch_seconds_o);
        end else begin
          oldest_expect = expected_epoch_q.pop_front();
          if (epoch_seconds_o !== oldest_expect.epoch) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("epoch mismatch for y%0d m%0d d%0d %0d:%0d:%0d: expected %0d, got %0d",
                       oldest_expect.date.yoff, oldest_expect.date.mon, oldest_expect.date.mday,
                       oldest_expect.date.hour, oldest_expect.date.min, oldest_expect.date.sec,
                       oldest_expect.epoch, epoch_seconds_o);
            end
          end
        end
      end
      stall_cycle <= stall_cycle + 1;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_done && results_seen == HOLD_AT_RESULT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else begin
        case (stall_cycle[9:8])
          2'd0:    out_ready_i <= 1'b1;
          2'd1:    out_ready_i <= ($urandom_range(0, 1) == 0);
          2'd2:    out_ready_i <= ($urandom_range(0, 7) == 0);
          default: out_ready_i <= (stall_cycle[2:0] != 3'd0);
        endcase
      end
    end
  end

  initial begin
    civil_date_t d;
    int          r_year;
    int          r_mon;
    int          r_mday;
    int          r_hour;
    int          r_min;
    int          r_sec;
    // Epoch itself, day zero at the epoch (wraps) and in February 1971, and years before 1970.
    add_date(70, 0, 1, 0, 0, 0);
    add_date(70, 0, 0, 0, 0, 0);
    add_date(0, 0, 1, 0, 0, 0);
    add_date(69, 15, 31, 31, 63, 63);
    add_date(71, 1, 0, 0, 0, 0);
    // Field extremes and unchecked values.
    add_date(255, 15, 31, 31, 63, 63);
    add_date(255, 11, 31, 23, 59, 60);
    add_date(70, 0, 31, 31, 63, 63);
    add_date(255, 0, 0, 0, 0, 0);
    // Leap rule: 2000 is a leap year, 2100 is not, 2004 is, 2003 is not.
    add_date(100, 1, 29, 12, 0, 0);
    add_date(100, 2, 1, 0, 0, 0);
    add_date(200, 2, 1, 0, 0, 0);
    add_date(201, 0, 1, 0, 0, 0);
    add_date(104, 2, 1, 0, 0, 0);
    add_date(103, 2, 1, 0, 0, 0);
    // Months beyond December.
    add_date(70, 12, 1, 0, 0, 0);
    add_date(70, 13, 1, 0, 0, 0);
    add_date(71, 14, 2, 3, 4, 5);
    add_date(72, 15, 1, 0, 0, 0);
    // Leap second, the 2038 boundary and the end of 2099.
    add_date(126, 5, 15, 10, 30, 60);
    add_date(138, 0, 19, 3, 14, 7);
    add_date(199, 11, 31, 23, 59, 59);

    for (int k = 0; k < RANDOM_DATES; k++) begin
      case ($urandom_range(0, 7))
        0:          r_year = $urandom_range(0, 69);
        1, 2, 3:    r_year = $urandom_range(70, 130);
        default:    r_year = $urandom_range(70, 255);
      endcase
      r_mon  = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 11);
      r_mday = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 31);
      r_hour = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 23);
      r_min  = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59);
      r_sec  = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 60);
      d = '0;
      d.yoff = r_year[cde_pkg::YEAR_W-1:0];
      d.mon  = r_mon[cde_pkg::MONTH_W-1:0];
      d.mday = r_mday[cde_pkg::MDAY_W-1:0];
      d.hour = r_hour[cde_pkg::HOUR_W-1:0];
      d.min  = r_min[cde_pkg::MIN_W-1:0];
      d.sec  = r_sec[cde_pkg::SEC_W-1:0];
      d.drain_first = (k == 0) || (k == RANDOM_DATES / 2);
      pending_dates_q.push_back(d);
    end

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_dates_q.size() != 0 || in_valid_i || expected_epoch_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout with %0d results outstanding", expected_epoch_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- files.f -----
sv/cde_pkg.sv
sv/cde_mac.sv
sv/cde_ctrl.sv
sv/civil_date_to_epoch_seconds.sv
tb/sv/civil_date_to_epoch_seconds_tb.sv
